### rtl/sfr_pkg.sv
// shared types and constants for the stuffed frame receiver
package sfr_pkg;

   // framing and escape bytes, control base and reset address
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_FLAG  = 8'h5E;
   localparam logic [7:0] ESC_ESC   = 8'h5D;
   localparam logic [7:0] CTRL_INFO = 8'h00;
   localparam logic [7:0] ADDR_RESET = 8'h03;

   // payload length limit and counter width
   localparam int COUNT_W = 12;
   localparam logic [COUNT_W-1:0] MAX_PAYLOAD = COUNT_W'(1024);

   // receive hunt states
   typedef enum logic [2:0] {
      HUNT_IDLE = 3'd0,
      HUNT_FLAG = 3'd1,
      HUNT_ADDR = 3'd2,
      HUNT_CTRL = 3'd3,
      HUNT_DATA = 3'd4
   } hunt_state_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_PAYLOAD  = 3'd0,
      KIND_GOOD     = 3'd1,
      KIND_MISMATCH = 3'd2,
      KIND_BAD_ESC  = 3'd3,
      KIND_OVERFLOW = 3'd4
   } result_kind_type;

   // one result item
   typedef struct packed {
      result_kind_type result_kind;
      logic [7:0]      out_byte;
      logic            frame_sequence;
   } rsp_item_type;

endpackage

### rtl/sfr_deframer.sv
// hunt state machine, destuffing and block check for one byte per cycle while byte_accept is high
module sfr_deframer import sfr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         byte_accept,
   input  logic [7:0]   rx_byte,
   input  logic [7:0]   address_byte,
   output logic         result_valid,
   output rsp_item_type result_item
);

   hunt_state_type     state_ff, state_in;
   logic               seq_ff, seq_in;
   logic               esc_ff, esc_in;
   logic [7:0]         held_ff, held_in;
   logic               held_valid_ff, held_valid_in;
   logic [7:0]         xor_ff, xor_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= HUNT_IDLE;
         seq_ff        <= 1'b0;
         esc_ff        <= 1'b0;
         held_ff       <= 8'h00;
         held_valid_ff <= 1'b0;
         xor_ff        <= 8'h00;
         count_ff      <= '0;
      end else if (byte_accept) begin
         state_ff      <= state_in;
         seq_ff        <= seq_in;
         esc_ff        <= esc_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         xor_ff        <= xor_in;
         count_ff      <= count_in;
      end
   end

   // next state and result for the byte on the input
   always_comb begin
      logic [7:0] ctrl;
      logic [7:0] data;
      logic       have_data;
      ctrl          = CTRL_INFO | {1'b0, seq_ff, 6'b0};
      data          = rx_byte;
      have_data     = 1'b0;
      state_in      = state_ff;
      seq_in        = seq_ff;
      esc_in        = esc_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      xor_in        = xor_ff;
      count_in      = count_ff;
      result_valid  = 1'b0;
      result_item.result_kind    = KIND_PAYLOAD;
      result_item.out_byte       = 8'h00;
      result_item.frame_sequence = seq_ff;
      case (state_ff)
         HUNT_FLAG: begin
            if (rx_byte == address_byte)  state_in = HUNT_ADDR;
            else if (rx_byte == FLAG_BYTE) state_in = HUNT_FLAG;
            else                           state_in = HUNT_IDLE;
         end
         HUNT_ADDR: begin
            if (rx_byte == ctrl)           state_in = HUNT_CTRL;
            else if (rx_byte == FLAG_BYTE) state_in = HUNT_FLAG;
            else                           state_in = HUNT_IDLE;
         end
         HUNT_CTRL: begin
            if (rx_byte == (address_byte ^ ctrl)) begin
               state_in      = HUNT_DATA;
               esc_in        = 1'b0;
               held_in       = 8'h00;
               held_valid_in = 1'b0;
               xor_in        = 8'h00;
               count_in      = '0;
            end else if (rx_byte == FLAG_BYTE) begin
               state_in = HUNT_FLAG;
            end else begin
               state_in = HUNT_IDLE;
            end
         end
         HUNT_DATA: begin
            if (rx_byte == FLAG_BYTE) begin
               // closing flag: escape error, good check or mismatch
               state_in     = HUNT_FLAG;
               result_valid = 1'b1;
               if (esc_ff) begin
                  esc_in                  = 1'b0;
                  result_item.result_kind = KIND_BAD_ESC;
               end else if (held_valid_ff && held_ff == xor_ff) begin
                  seq_in                  = ~seq_ff;
                  result_item.result_kind = KIND_GOOD;
               end else begin
                  result_item.result_kind = KIND_MISMATCH;
               end
            end else if (esc_ff) begin
               // second byte of an escape pair
               esc_in = 1'b0;
               if (rx_byte == ESC_FLAG) begin
                  data      = FLAG_BYTE;
                  have_data = 1'b1;
               end else if (rx_byte == ESC_ESC) begin
                  data      = ESC_BYTE;
                  have_data = 1'b1;
               end else begin
                  state_in                = HUNT_IDLE;
                  result_valid            = 1'b1;
                  result_item.result_kind = KIND_BAD_ESC;
               end
            end else if (rx_byte == ESC_BYTE) begin
               esc_in = 1'b1;
            end else begin
               have_data = 1'b1;
            end
            // held byte goes out when a new one displaces it
            if (have_data) begin
               if (held_valid_ff) begin
                  result_valid = 1'b1;
                  if (count_ff >= MAX_PAYLOAD) begin
                     state_in                = HUNT_IDLE;
                     result_item.result_kind = KIND_OVERFLOW;
                  end else begin
                     xor_in               = xor_ff ^ held_ff;
                     count_in             = count_ff + COUNT_W'(1);
                     held_in              = data;
                     result_item.out_byte = held_ff;
                  end
               end else begin
                  held_in       = data;
                  held_valid_in = 1'b1;
               end
            end
         end
         default: begin
            if (rx_byte == FLAG_BYTE) state_in = HUNT_FLAG;
            else                      state_in = HUNT_IDLE;
         end
      endcase
   end

endmodule

### rtl/sfr_rsp_buffer.sv
// result register with a skid stage so input keeps flowing while output stalls, until the skid stage fills
module sfr_rsp_buffer import sfr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         has_space,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         pop;

   assign pop       = out_valid_ff & rsp_ready;
   assign has_space = ~skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // next contents of output and skid stages
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_item_in  = push_item;
            out_valid_in = 1'b1;
         end else begin
            skid_item_in  = push_item;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule

### rtl/stuffed_frame_receiver.sv
// top level: byte-stuffed frame receiver with xor block check
// output: result items are registered in the result or skid stage before rsp_tvalid
// throughput: one byte per cycle; req_tready drops only when both the result
//   register and the skid stage hold items
// reset: clears hunt state, sequence bit, escape flag, held byte, xor and count,
//   empties the result stages and sets the address register to 0x03
module stuffed_frame_receiver import sfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,  // address_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] out_byte, [8] frame_sequence, [15:9] zero
   output logic [2:0]  rsp_tuser     // [2:0] result_kind
);

   logic [7:0]   address_ff;
   logic         byte_accept;
   logic         result_valid;
   rsp_item_type result_item;
   rsp_item_type rsp_item;
   logic         has_space;

   // address register
   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= ADDR_RESET;
      end else if (csr_wr_en) begin
         address_ff <= csr_wr_data;
      end
   end

   assign req_tready  = has_space;
   assign byte_accept = req_tvalid & req_tready;

   sfr_deframer u_deframer (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (byte_accept),
      .rx_byte      (req_tdata),
      .address_byte (address_ff),
      .result_valid (result_valid),
      .result_item  (result_item)
   );

   sfr_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (byte_accept & result_valid),
      .push_item (result_item),
      .has_space (has_space),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   // pack result fields
   assign rsp_tdata = {7'b0, rsp_item.frame_sequence, rsp_item.out_byte};
   assign rsp_tuser = rsp_item.result_kind;

`ifndef SYNTH
   // a full skid stage implies the result register is occupied
   a_stall_has_item: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result item pending");

   // status items carry a zero byte
   a_status_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_PAYLOAD |-> rsp_tdata[7:0] == 8'h00)
      else $error("status item with nonzero byte");

   // after reset the input side is open
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");
`endif

endmodule

### tb/tb_top.sv
// testbench for the stuffed frame receiver: framed byte traffic checked against a predictor
`timescale 1ns / 1ps

module tb_top;
   import sfr_pkg::*;

   // kinds of line traffic the frame builder can produce
   typedef enum int {
      FR_GOOD,
      FR_BAD_BCC,
      FR_BAD_ESC,
      FR_BAD_ESC_FLAG,
      FR_EMPTY,
      FR_BAD_HDR
   } frame_mode_type;

   // predicts deframer results and checks them in order
   class frame_scoreboard;
      logic [7:0]         address;
      hunt_state_type     hunt;
      logic               seq;
      logic               esc;
      logic [7:0]         held;
      logic               held_ok;
      logic [7:0]         xor_acc;
      logic [COUNT_W-1:0] count;
      rsp_item_type       pending[$];
      int                 errors;
      int                 n_payload;
      int                 n_good;
      int                 n_bad;

      function new();
         address   = ADDR_RESET;
         hunt      = HUNT_IDLE;
         seq       = 1'b0;
         esc       = 1'b0;
         held      = 8'h00;
         held_ok   = 1'b0;
         xor_acc   = 8'h00;
         count     = '0;
         errors    = 0;
         n_payload = 0;
         n_good    = 0;
         n_bad     = 0;
      endfunction

      function void set_address(logic [7:0] a);
         address = a;
      endfunction

      function int pending_count();
         return pending.size();
      endfunction

      // advance the deframer state by one accepted line byte
      function void note_byte(logic [7:0] b);
         logic [7:0]   ctrl;
         logic [7:0]   d;
         logic         have;
         logic         emit;
         rsp_item_type r;
         ctrl = CTRL_INFO | {1'b0, seq, 6'd0};
         emit = 1'b0;
         have = 1'b0;
         d = b;
         r.result_kind = KIND_PAYLOAD;
         r.out_byte = 8'h00;
         r.frame_sequence = seq;
         case (hunt)
            HUNT_FLAG: begin
               if (b == address) hunt = HUNT_ADDR;
               else if (b == FLAG_BYTE) hunt = HUNT_FLAG;
               else hunt = HUNT_IDLE;
            end
            HUNT_ADDR: begin
               if (b == ctrl) hunt = HUNT_CTRL;
               else if (b == FLAG_BYTE) hunt = HUNT_FLAG;
               else hunt = HUNT_IDLE;
            end
            HUNT_CTRL: begin
               if (b == (address ^ ctrl)) begin
                  hunt    = HUNT_DATA;
                  esc     = 1'b0;
                  held    = 8'h00;
                  held_ok = 1'b0;
                  xor_acc = 8'h00;
                  count   = '0;
               end else if (b == FLAG_BYTE) begin
                  hunt = HUNT_FLAG;
               end else begin
                  hunt = HUNT_IDLE;
               end
            end
            HUNT_DATA: begin
               if (b == FLAG_BYTE) begin
                  // closing flag also opens the next frame
                  hunt = HUNT_FLAG;
                  emit = 1'b1;
                  if (esc) begin
                     esc = 1'b0;
                     r.result_kind = KIND_BAD_ESC;
                  end else if (held_ok && held == xor_acc) begin
                     r.result_kind = KIND_GOOD;
                     seq = ~seq;
                  end else begin
                     r.result_kind = KIND_MISMATCH;
                  end
               end else if (esc) begin
                  esc = 1'b0;
                  have = 1'b1;
                  if (b == ESC_FLAG) d = FLAG_BYTE;
                  else if (b == ESC_ESC) d = ESC_BYTE;
                  else begin
                     have = 1'b0;
                     hunt = HUNT_IDLE;
                     emit = 1'b1;
                     r.result_kind = KIND_BAD_ESC;
                  end
               end else if (b == ESC_BYTE) begin
                  esc = 1'b1;
               end else begin
                  have = 1'b1;
               end
               // destuffed byte displaces the held one
               if (have) begin
                  if (!held_ok) begin
                     held = d;
                     held_ok = 1'b1;
                  end else if (count >= MAX_PAYLOAD) begin
                     hunt = HUNT_IDLE;
                     emit = 1'b1;
                     r.result_kind = KIND_OVERFLOW;
                  end else begin
                     xor_acc = xor_acc ^ held;
                     count = count + COUNT_W'(1);
                     emit = 1'b1;
                     r.out_byte = held;
                     held = d;
                  end
               end
            end
            default: begin
               if (b == FLAG_BYTE) hunt = HUNT_FLAG;
               else hunt = HUNT_IDLE;
            end
         endcase
         if (emit) pending.push_back(r);
      endfunction

      // compare one result item with the oldest prediction
      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (pending.size() == 0) begin
            $error("unexpected result: kind %0d byte %0d seq %0d",
                   got.result_kind, got.out_byte, got.frame_sequence);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.result_kind != want.result_kind) begin
            $error("result_kind: expected %0d, actual %0d", want.result_kind, got.result_kind);
            errors++;
         end
         if (got.out_byte != want.out_byte) begin
            $error("out_byte: expected %0d, actual %0d", want.out_byte, got.out_byte);
            errors++;
         end
         if (got.frame_sequence != want.frame_sequence) begin
            $error("frame_sequence: expected %0d, actual %0d",
                   want.frame_sequence, got.frame_sequence);
            errors++;
         end
         case (want.result_kind)
            KIND_PAYLOAD: n_payload++;
            KIND_GOOD:    n_good++;
            default:      n_bad++;
         endcase
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [15:0] rsp_tdata;           // [7:0] out_byte, [8] frame_sequence, [15:9] zero
   logic [2:0]  rsp_tuser;           // [2:0] result_kind

   frame_scoreboard sb;
   logic [7:0]      frame_payload[$];
   logic [7:0]      line_buf[$];
   bit              idle_on = 1'b1;
   int              item_total = 0;
   int              stall_left = 0;

   stuffed_frame_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #2 clock = ~clock;

   // result side: check accepted items, stall in short bursts
   always @(posedge clock) begin
      rsp_item_type got;
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.result_kind    = result_kind_type'(rsp_tuser);
         got.out_byte       = rsp_tdata[7:0];
         got.frame_sequence = rsp_tdata[8];
         sb.check_result(got);
      end
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(1, 3) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // offer one line byte, with an occasional idle burst before it
   task automatic send_byte(input logic [7:0] b, input bit counted);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.note_byte(b);
      if (counted) item_total++;
   endtask

   // append a byte to the line, stuffing flag and escape
   function void push_stuffed(logic [7:0] v);
      if (v == FLAG_BYTE) begin
         line_buf.push_back(ESC_BYTE);
         line_buf.push_back(ESC_FLAG);
      end else if (v == ESC_BYTE) begin
         line_buf.push_back(ESC_BYTE);
         line_buf.push_back(ESC_ESC);
      end else begin
         line_buf.push_back(v);
      end
   endfunction

   // build one frame around frame_payload and send it
   task automatic send_frame(input frame_mode_type mode);
      logic [7:0] ctrl;
      logic [7:0] bcc;
      logic [7:0] wrong;
      logic [7:0] hdr[3];
      logic [7:0] bad;
      int         pos;
      int         k;
      line_buf.delete();
      ctrl = CTRL_INFO | {1'b0, sb.seq, 6'd0};
      // a closing flag may double as the opening one
      if (!(sb.hunt == HUNT_FLAG && $urandom_range(0, 1) == 0)) line_buf.push_back(FLAG_BYTE);
      hdr[0] = sb.address;
      hdr[1] = ctrl;
      hdr[2] = sb.address ^ ctrl;
      if (mode == FR_BAD_HDR) begin
         pos = $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) wrong = FLAG_BYTE;
         else if (pos == 1 && $urandom_range(0, 1) == 0) wrong = ctrl ^ 8'h40;
         else wrong = 8'($urandom_range(0, 255));
         if (wrong == hdr[pos]) wrong = wrong ^ 8'h01;
         hdr[pos] = wrong;
      end
      for (int i = 0; i < 3; i++) line_buf.push_back(hdr[i]);
      // payload, with a broken escape where asked
      k = $urandom_range(0, frame_payload.size());
      bad = 8'($urandom_range(0, 255));
      if (bad == ESC_FLAG || bad == ESC_ESC) bad = 8'h00;
      if (mode == FR_BAD_ESC_FLAG) bad = FLAG_BYTE;
      bcc = 8'h00;
      if (mode != FR_EMPTY) begin
         for (int i = 0; i <= frame_payload.size(); i++) begin
            if (i == k && (mode == FR_BAD_ESC || mode == FR_BAD_ESC_FLAG)) begin
               line_buf.push_back(ESC_BYTE);
               line_buf.push_back(bad);
            end
            if (i < frame_payload.size()) begin
               bcc = bcc ^ frame_payload[i];
               push_stuffed(frame_payload[i]);
            end
         end
         if (mode == FR_BAD_BCC) bcc = bcc ^ (8'h01 << $urandom_range(0, 7));
         push_stuffed(bcc);
      end
      line_buf.push_back(FLAG_BYTE);
      foreach (line_buf[i]) send_byte(line_buf[i], 1'b1);
   endtask

   // fill frame_payload with random bytes, framing bytes now and then
   task automatic random_payload(input int len);
      frame_payload.delete();
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 11))
            0:       frame_payload.push_back(FLAG_BYTE);
            1:       frame_payload.push_back(ESC_BYTE);
            default: frame_payload.push_back(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   // stop offering, wait for all results and the pipeline to empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_address(input logic [7:0] a);
      csr_wr_data <= a;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_address(a);
   endtask

   // random traffic: mostly well-formed frames, some broken, some noise
   task automatic run_phase(input int quota, input bit with_overflow);
      int start;
      int pick;
      int len;
      start = item_total;
      if (with_overflow) begin
         random_payload(MAX_PAYLOAD + 1);
         send_frame(FR_GOOD);
      end
      while (item_total - start < quota) begin
         pick = $urandom_range(0, 99);
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         random_payload(len);
         if (pick < 50) send_frame(FR_GOOD);
         else if (pick < 60) send_frame(FR_BAD_BCC);
         else if (pick < 67) send_frame(FR_BAD_ESC);
         else if (pick < 70) send_frame(FR_BAD_ESC_FLAG);
         else if (pick < 75) send_frame(FR_EMPTY);
         else if (pick < 88) send_frame(FR_BAD_HDR);
         else begin
            // line noise between frames
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 3) == 0) send_byte(FLAG_BYTE, 1'b0);
               else send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
         end
      end
   endtask

   // main sequence
   initial begin
      logic [7:0] phase_addr[7];
      sb = new();
      phase_addr[0] = 8'h00;
      phase_addr[1] = 8'hFF;
      phase_addr[2] = FLAG_BYTE;
      phase_addr[3] = ESC_BYTE;
      phase_addr[4] = 8'($urandom_range(0, 255));
      phase_addr[5] = 8'($urandom_range(0, 255));
      phase_addr[6] = ADDR_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: escapes and byte extremes, empty frame, flag after escape
      frame_payload = {FLAG_BYTE, ESC_BYTE, 8'h00, 8'hFF};
      send_frame(FR_GOOD);
      frame_payload.delete();
      send_frame(FR_EMPTY);
      frame_payload = {8'h55};
      send_frame(FR_BAD_ESC_FLAG);
      // flag during the header restarts the hunt
      send_byte(FLAG_BYTE, 1'b1);
      send_byte(ADDR_RESET, 1'b1);
      send_byte(FLAG_BYTE, 1'b1);
      frame_payload = {8'hA5};
      send_frame(FR_GOOD);

      for (int p = 0; p < 7; p++) begin
         settle();
         write_address(phase_addr[p]);
         if (p == 6) idle_on = 1'b0;
         run_phase((p == 4) ? 1100 : 60, p == 4);
      end

      settle();
      repeat (10) @(posedge clock);
      $display("sent %0d frame bytes over 8 address settings", item_total);
      $display("results: %0d payload bytes, %0d good frames, %0d frame errors",
               sb.n_payload, sb.n_good, sb.n_bad);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
rtl/sfr_pkg.sv
rtl/sfr_deframer.sv
rtl/sfr_rsp_buffer.sv
rtl/stuffed_frame_receiver.sv
tb/tb_top.sv
